FILE: hdl/nnau_pkg.sv
// Shared constants, types and the sigmoid sample table for the activation unit.
`timescale 1ns / 1ps
`default_nettype none

package nnau_pkg;

   // Number format
   localparam int DATA_WIDTH    = 16;
   localparam int FRAC_BITS     = 12;
   localparam int LEAK_W        = 16;
   localparam logic [LEAK_W-1:0] LEAK_RESET = 16'd655;

   // Table geometry: TABLE_ENTRIES+1 samples over [0, 16]
   localparam int TABLE_ENTRIES = 256;
   localparam int TABLE_BITS    = $clog2(TABLE_ENTRIES);
   localparam int SPAN_BITS     = 4;
   localparam int DEN_BITS      = FRAC_BITS + SPAN_BITS;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);

   // Datapath widths
   localparam int V_W      = DATA_WIDTH + 1;            // |x| or 2|x|
   localparam int N_W      = V_W + TABLE_BITS;          // v * entries
   localparam int QT_W     = N_W - DEN_BITS;            // raw segment number
   localparam int Q_W      = 31;                        // Q0.30 values up to 1.0
   localparam int PROD_W   = Q_W + DEN_BITS;            // slope * remainder
   localparam int MP_W     = 2 * Q_W;                   // Q0.30 square
   localparam int LIN_W    = DATA_WIDTH + 1;            // relu family results
   localparam int LP_W     = DATA_WIDTH + LEAK_W + 1;   // |x| * slope + half
   localparam int LD_W     = LEAK_W + FRAC_BITS + 1;    // slope in Q FRAC + half
   localparam int FIX_SHIFT = 30 - FRAC_BITS;
   localparam int FX_W     = Q_W + 1 - FIX_SHIFT;
   localparam int RES_W    = (FX_W + 1 > DATA_WIDTH + 2) ? FX_W + 1 : DATA_WIDTH + 2;
   localparam int PIPE_STAGES = 6;

   localparam logic [Q_W-1:0]       Q30_ONE  = Q_W'(64'd1 << 30);
   localparam logic [MP_W:0]        Q30_RND  = (MP_W+1)'(64'd1 << 29);
   localparam logic [PROD_W-1:0]    DEN_RND  = PROD_W'(64'd1 << (DEN_BITS - 1));
   localparam logic [Q_W:0]         FIX_RND  = (Q_W+1)'(64'd1 << (FIX_SHIFT - 1));
   localparam logic signed [LIN_W-1:0] LIN_ONE = LIN_W'(64'd1 << FRAC_BITS);
   localparam logic [LP_W-1:0]      LP_RND   = LP_W'(64'd1 << (LEAK_W - 1));
   localparam logic [LD_W-1:0]      LD_RND   = LD_W'(64'd1 << (LEAK_W - 1));
   localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

   typedef enum logic [2:0] {
      OP_SIGMOID     = 3'd0,
      OP_SIG_DERIV   = 3'd1,
      OP_RELU        = 3'd2,
      OP_RELU_DERIV  = 3'd3,
      OP_LEAKY       = 3'd4,
      OP_LEAKY_DERIV = 3'd5,
      OP_TANH        = 3'd6,
      OP_TANH_DERIV  = 3'd7
   } opcode_type;

   // Per-item sideband that rides along with the table path
   typedef struct packed {
      opcode_type              op;
      logic                    neg;
      logic signed [LIN_W-1:0] lin;   // finished relu / leaky result
   } side_type;

   // Load enables of three consecutive pipeline stages
   typedef struct packed {
      logic st_a;
      logic st_b;
      logic st_c;
   } stage_en_type;

   typedef logic [31:0] sig_tab_type [TABLE_ENTRIES+1];

   // Shift-subtract division, elaboration use only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sigmoid(u) samples in Q0.30; exp(-step) from a 24-term series
   function automatic sig_tab_type build_sig_tab();
      sig_tab_type        tab;
      logic [63:0]        h;
      logic [63:0]        term;
      logic [63:0]        base;
      logic [63:0]        e;
      logic [63:0]        d;
      logic signed [63:0] sum;
      h    = 64'd1 << (34 - TABLE_BITS);
      sum  = 64'sd1 <<< 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
         term = udiv64((term * h + (64'd1 << 29)) >> 30, 64'(k));
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      base = $unsigned(sum);
      e    = 64'd1 << 30;
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         if (i > 0) begin
            e = (e * base + (64'd1 << 29)) >> 30;
         end
         d      = (64'd1 << 30) + e;
         tab[i] = 32'(udiv64((64'd1 << 60) + (d >> 1), d));
      end
      return tab;
   endfunction

   localparam sig_tab_type SIG_TAB = build_sig_tab();

endpackage

`default_nettype wire

FILE: hdl/nn_activation_unit_core.sv
// Top level of the activation unit: handshake, valid pipeline and slope register.
// Each accepted item passes through six register stages before rsp_valid rises for it;
// the result is taken on an edge where rsp_ready is also high.
// Throughput: one item per cycle, set by the six-stage pipeline (table read and
// two multiplier stages); each stage holds its item until the next one is free.
// Reset (synchronous, active high) empties the pipeline and sets leak_slope to 655.
`timescale 1ns / 1ps
`default_nettype none

module nn_activation_unit_core import nnau_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [2:0]                   req_opcode,
   input  wire logic signed [DATA_WIDTH-1:0] req_x_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0]      rsp_y_value,
   input  wire logic                         csr_wr_en,
   input  wire logic [LEAK_W-1:0]            csr_wr_data
);

   logic [LEAK_W-1:0]      leak_ff, leak_in;
   logic [PIPE_STAGES-1:0] vld_ff, vld_in;
   logic [PIPE_STAGES-1:0] rdy_c;
   stage_en_type           en_front;
   stage_en_type           en_back;
   logic [Q_W-1:0]         lo_w;
   logic [PROD_W-1:0]      prod_w;
   side_type               side_w;
   logic [DATA_WIDTH-1:0]  y_w;

   assign leak_in = csr_wr_en ? csr_wr_data : leak_ff;

   // a stage loads when it is empty or the stage after it moves on
   always_comb begin
      rdy_c[PIPE_STAGES-1] = rsp_ready || !vld_ff[PIPE_STAGES-1];
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         rdy_c[k] = rdy_c[k+1] || !vld_ff[k];
      end
      vld_in[0] = rdy_c[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         vld_in[k] = rdy_c[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         leak_ff <= LEAK_RESET;
      end else begin
         vld_ff  <= vld_in;
         leak_ff <= leak_in;
      end
   end

   assign en_front.st_a = rdy_c[0];
   assign en_front.st_b = rdy_c[1];
   assign en_front.st_c = rdy_c[2];
   assign en_back.st_a  = rdy_c[3];
   assign en_back.st_b  = rdy_c[4];
   assign en_back.st_c  = rdy_c[5];

   nnau_interp u_interp (
      .clock      (clock),
      .en         (en_front),
      .op_in      (opcode_type'(req_opcode)),
      .x_in       (req_x_value),
      .leak_slope (leak_ff),
      .lo_out     (lo_w),
      .prod_out   (prod_w),
      .side_out   (side_w)
   );

   nnau_finish u_finish (
      .clock   (clock),
      .en      (en_back),
      .lo_in   (lo_w),
      .prod_in (prod_w),
      .side_in (side_w),
      .y_out   (y_w)
   );

   assign req_ready   = rdy_c[0];
   assign rsp_valid   = vld_ff[PIPE_STAGES-1];
   assign rsp_y_value = $signed(y_w);

endmodule

`default_nettype wire

FILE: hdl/nnau_interp.sv
// Front stages: operand fold, table read, leaky relu terms and interpolation multiply.
`timescale 1ns / 1ps
`default_nettype none

module nnau_interp import nnau_pkg::*; (
   input  wire logic                         clock,
   input  wire stage_en_type                 en,
   input  wire opcode_type                   op_in,
   input  wire logic signed [DATA_WIDTH-1:0] x_in,
   input  wire logic [LEAK_W-1:0]            leak_slope,
   output logic [Q_W-1:0]                    lo_out,
   output logic [PROD_W-1:0]                 prod_out,
   output side_type                          side_out
);

   // stage 1: fold to |x| (2|x| for tanh), split into segment and remainder
   logic [DATA_WIDTH-1:0] xu_c;
   logic                  neg_c;
   logic [DATA_WIDTH-1:0] u_c;
   logic                  tanh_c;
   logic [V_W-1:0]        v_c;
   logic [N_W-1:0]        n_c;
   logic [QT_W-1:0]       q_c;

   logic [IDX_W-1:0]            idx1_in, idx1_ff;
   logic [DEN_BITS-1:0]         r1_in, r1_ff;
   logic [DATA_WIDTH-1:0]       u1_ff;
   logic signed [DATA_WIDTH-1:0] x1_ff;
   opcode_type                  op1_ff;
   logic                        neg1_ff;

   always_comb begin
      xu_c    = x_in;
      neg_c   = xu_c[DATA_WIDTH-1];
      u_c     = neg_c ? (~xu_c + 1'b1) : xu_c;
      tanh_c  = (op_in == OP_TANH) || (op_in == OP_TANH_DERIV);
      v_c     = tanh_c ? {u_c, 1'b0} : {1'b0, u_c};
      n_c     = {v_c, {TABLE_BITS{1'b0}}};
      q_c     = n_c[N_W-1:DEN_BITS];
      // past the last segment the final sample is used as is
      idx1_in = (q_c >= QT_W'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES) : IDX_W'(q_c);
      r1_in   = n_c[DEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.st_a) begin
         idx1_ff <= idx1_in;
         r1_ff   <= r1_in;
         u1_ff   <= u_c;
         x1_ff   <= x_in;
         op1_ff  <= op_in;
         neg1_ff <= neg_c;
      end
   end

   // stage 2: table samples, slope, relu family result
   logic [IDX_W-1:0]  hi_idx_c;
   logic [Q_W-1:0]    lo_c;
   logic [Q_W-1:0]    hi_c;
   logic [LP_W-1:0]   lp_c;
   logic [LIN_W-1:0]  mag_c;
   logic [LD_W-1:0]   ld_c;
   logic              pos_c;
   logic signed [LIN_W-1:0] lin_c;
   logic signed [LIN_W-1:0] xl_c;

   logic [Q_W-1:0]      lo2_in, lo2_ff;
   logic [Q_W-1:0]      diff2_in, diff2_ff;
   logic [DEN_BITS-1:0] r2_ff;
   side_type            side2_in, side2_ff;

   always_comb begin
      hi_idx_c = (idx1_ff == IDX_W'(TABLE_ENTRIES)) ? idx1_ff : idx1_ff + 1'b1;
      lo_c     = SIG_TAB[idx1_ff][Q_W-1:0];
      hi_c     = SIG_TAB[hi_idx_c][Q_W-1:0];
      lo2_in   = lo_c;
      diff2_in = (hi_c > lo_c) ? (hi_c - lo_c) : '0;

      // leaky magnitude rounds half up
      lp_c  = LP_W'(u1_ff) * LP_W'(leak_slope) + LP_RND;
      mag_c = lp_c[LP_W-1:LEAK_W];
      ld_c  = LD_W'({leak_slope, {FRAC_BITS{1'b0}}}) + LD_RND;

      pos_c = !x1_ff[DATA_WIDTH-1] && (x1_ff != '0);
      xl_c  = {x1_ff[DATA_WIDTH-1], x1_ff};

      case (op1_ff)
         OP_RELU:        lin_c = pos_c ? xl_c : '0;
         OP_RELU_DERIV:  lin_c = pos_c ? LIN_ONE : '0;
         OP_LEAKY:       lin_c = pos_c ? xl_c : ($signed(LIN_W'(0)) - $signed(mag_c));
         OP_LEAKY_DERIV: lin_c = pos_c ? LIN_ONE : $signed(LIN_W'(ld_c[LD_W-1:LEAK_W]));
         default:        lin_c = '0;
      endcase

      side2_in.op  = op1_ff;
      side2_in.neg = neg1_ff;
      side2_in.lin = lin_c;
   end

   always_ff @(posedge clock) begin
      if (en.st_b) begin
         lo2_ff   <= lo2_in;
         diff2_ff <= diff2_in;
         r2_ff    <= r1_ff;
         side2_ff <= side2_in;
      end
   end

   // stage 3: slope times remainder
   logic [PROD_W-1:0] prod3_in, prod3_ff;
   logic [Q_W-1:0]    lo3_ff;
   side_type          side3_ff;

   assign prod3_in = PROD_W'(diff2_ff) * PROD_W'(r2_ff);

   always_ff @(posedge clock) begin
      if (en.st_c) begin
         prod3_ff <= prod3_in;
         lo3_ff   <= lo2_ff;
         side3_ff <= side2_ff;
      end
   end

   assign lo_out   = lo3_ff;
   assign prod_out = prod3_ff;
   assign side_out = side3_ff;

endmodule

`default_nettype wire

FILE: hdl/nnau_finish.sv
// Back stages: interpolated sigmoid, derivative square, result select and saturation.
`timescale 1ns / 1ps
`default_nettype none

module nnau_finish import nnau_pkg::*; (
   input  wire logic                  clock,
   input  wire stage_en_type          en,
   input  wire logic [Q_W-1:0]        lo_in,
   input  wire logic [PROD_W-1:0]     prod_in,
   input  wire side_type              side_in,
   output logic [DATA_WIDTH-1:0]      y_out
);

   // stage 4: finish interpolation, form tanh and multiplier operands
   logic [PROD_W-1:0] rnd_c;
   logic [Q_W-1:0]    s_c;
   logic [Q_W-1:0]    t_c;

   logic [Q_W-1:0] s4_ff, t4_ff;
   logic [Q_W-1:0] ma4_in, ma4_ff;
   logic [Q_W-1:0] mb4_in, mb4_ff;
   side_type       side4_ff;

   always_comb begin
      rnd_c = prod_in + DEN_RND;
      s_c   = lo_in + rnd_c[PROD_W-1:DEN_BITS];
      // sigmoid of |x| is at least one half, so t stays non-negative
      t_c   = {s_c[Q_W-2:0], 1'b0} - Q30_ONE;
      if (side_in.op == OP_SIG_DERIV) begin
         ma4_in = s_c;
         mb4_in = Q30_ONE - s_c;
      end else begin
         ma4_in = t_c;
         mb4_in = t_c;
      end
   end

   always_ff @(posedge clock) begin
      if (en.st_a) begin
         s4_ff    <= s_c;
         t4_ff    <= t_c;
         ma4_ff   <= ma4_in;
         mb4_ff   <= mb4_in;
         side4_ff <= side_in;
      end
   end

   // stage 5: s*(1-s) or t*t
   logic [MP_W-1:0] p5_in, p5_ff;
   logic [Q_W-1:0]  s5_ff, t5_ff;
   side_type        side5_ff;

   assign p5_in = MP_W'(ma4_ff) * MP_W'(mb4_ff);

   always_ff @(posedge clock) begin
      if (en.st_b) begin
         p5_ff    <= p5_in;
         s5_ff    <= s4_ff;
         t5_ff    <= t4_ff;
         side5_ff <= side4_ff;
      end
   end

   // stage 6: round to Q FRAC, select, saturate
   logic [MP_W:0]   pr_sum_c;
   logic [Q_W-1:0]  pr_c;
   logic [Q_W-1:0]  q_c;
   logic [Q_W:0]    fx_sum_c;
   logic [FX_W-1:0] fix_c;
   logic signed [RES_W-1:0] fixs_c;
   logic signed [RES_W-1:0] res_c;
   logic [DATA_WIDTH-1:0]   y6_in, y6_ff;

   always_comb begin
      pr_sum_c = {1'b0, p5_ff} + Q30_RND;
      pr_c     = pr_sum_c[30 +: Q_W];
      case (side5_ff.op)
         OP_SIGMOID:    q_c = side5_ff.neg ? (Q30_ONE - s5_ff) : s5_ff;
         OP_SIG_DERIV:  q_c = pr_c;
         OP_TANH:       q_c = t5_ff;
         OP_TANH_DERIV: q_c = Q30_ONE - pr_c;
         default:       q_c = '0;
      endcase
      fx_sum_c = {1'b0, q_c} + FIX_RND;
      fix_c    = fx_sum_c[Q_W:FIX_SHIFT];
      fixs_c   = $signed({{(RES_W-FX_W){1'b0}}, fix_c});

      case (side5_ff.op)
         OP_SIGMOID,
         OP_SIG_DERIV,
         OP_TANH_DERIV:  res_c = fixs_c;
         OP_TANH:        res_c = side5_ff.neg ? -fixs_c : fixs_c;
         OP_RELU,
         OP_RELU_DERIV,
         OP_LEAKY,
         OP_LEAKY_DERIV: res_c = {{(RES_W-LIN_W){side5_ff.lin[LIN_W-1]}}, side5_ff.lin};
         default:        res_c = '0;
      endcase

      if (res_c > SAT_MAX) begin
         y6_in = SAT_MAX[DATA_WIDTH-1:0];
      end else if (res_c < SAT_MIN) begin
         y6_in = SAT_MIN[DATA_WIDTH-1:0];
      end else begin
         y6_in = res_c[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.st_c) begin
         y6_ff <= y6_in;
      end
   end

   assign y_out = y6_ff;

endmodule

`default_nettype wire

FILE: hdl/nnau_checker.sv
// Port-level checks for the activation unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nnau_checker import nnau_pkg::*; (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic signed [DATA_WIDTH-1:0] rsp_y_value
);

   // a stalled item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_value))
      else $error("rsp item changed while stalled");

   // reset leaves the pipeline empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // when the result side takes an item every stage advances
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is taken");

   // an empty output stage never blocks the input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

endmodule

bind nn_activation_unit_core nnau_checker u_nnau_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for nn_activation_unit_core: random traffic, idling, slope changes.
`timescale 1ns / 1ps

module testbench;
   import nnau_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SPAN_SHIFT   = 4;                        // table spans [0, 16)
   localparam longint unsigned Q30_UNIT = 64'd1 << 30;
   localparam longint unsigned Q30_HALF = 64'd1 << 29;
   localparam longint SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef struct packed {
      opcode_type                     op;
      logic signed [DATA_WIDTH-1:0]   x;
   } operand_item_type;

   typedef struct packed {
      opcode_type                     op;
      logic signed [DATA_WIDTH-1:0]   x;
      logic signed [DATA_WIDTH-1:0]   y;
   } activation_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [2:0]                     req_opcode = '0;
   logic signed [DATA_WIDTH-1:0]   req_x_value = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [DATA_WIDTH-1:0]   rsp_y_value;
   logic                           csr_wr_en = 1'b0;
   logic [LEAK_W-1:0]              csr_wr_data = '0;

   nn_activation_unit_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_x_value (req_x_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_y_value (rsp_y_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   operand_item_type       pending_operands[$];
   activation_result_type  awaited_results[$];
   longint unsigned   sigmoid_knots [0:TABLE_ENTRIES];
   logic [LEAK_W-1:0] slope_shadow = LEAK_RESET;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   // driver / monitor working state
   operand_item_type       drv_item;
   activation_result_type  drv_expect;
   activation_result_type  mon_expect;
   int                launch_gap = 0;
   int                launch_calm = 0;
   int                stall_left = 0;
   int                accept_calm = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // sigmoid(16*i/N) in Q0.30, exp(-step) from a 24-term series
   function automatic void build_sigmoid_knots();
      longint unsigned step;
      longint unsigned term;
      longint unsigned decay;
      longint unsigned e;
      longint unsigned d;
      longint          acc;
      step = (64'd1 << 34) / TABLE_ENTRIES;
      acc  = longint'(Q30_UNIT);
      term = Q30_UNIT;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * step + Q30_HALF) >> 30) / longint'(k);
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      decay = acc;
      e = Q30_UNIT;
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         if (i > 0) begin
            e = (e * decay + Q30_HALF) >> 30;
         end
         d = Q30_UNIT + e;
         sigmoid_knots[i] = ((64'd1 << 60) + d / 2) / d;
      end
   endfunction

   // interpolated sigmoid of a non-negative Q FRAC_BITS magnitude, Q0.30 out
   function automatic longint unsigned sigmoid_q30(input longint unsigned mag);
      longint unsigned n;
      longint unsigned den;
      longint unsigned idx;
      longint unsigned rem;
      longint unsigned lo;
      longint unsigned hi;
      n   = mag * TABLE_ENTRIES;
      den = 64'd1 << (FRAC_BITS + SPAN_SHIFT);
      idx = n / den;
      rem = n % den;
      if (idx >= TABLE_ENTRIES) begin
         return sigmoid_knots[TABLE_ENTRIES];
      end
      lo = sigmoid_knots[idx];
      hi = sigmoid_knots[idx + 1];
      if (hi <= lo) begin
         return lo;
      end
      return lo + ((hi - lo) * rem + den / 2) / den;
   endfunction

   function automatic longint q30_to_fixed(input longint unsigned v);
      return longint'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] activation_value(
      input opcode_type op, input logic signed [DATA_WIDTH-1:0] x,
      input logic [LEAK_W-1:0] slope);
      longint          xv;
      longint          y;
      longint unsigned mag;
      longint unsigned s;
      longint unsigned t;
      longint unsigned sl;
      xv  = x;
      mag = (xv < 0) ? -xv : xv;
      sl  = slope;
      y   = 0;
      case (op)
         OP_SIGMOID: begin
            s = sigmoid_q30(mag);
            y = q30_to_fixed((xv < 0) ? Q30_UNIT - s : s);
         end
         OP_SIG_DERIV: begin
            s = sigmoid_q30(mag);
            y = q30_to_fixed((s * (Q30_UNIT - s) + Q30_HALF) >> 30);
         end
         OP_RELU: begin
            y = (xv > 0) ? xv : 0;
         end
         OP_RELU_DERIV: begin
            y = (xv > 0) ? (64'sd1 <<< FRAC_BITS) : 0;
         end
         OP_LEAKY: begin
            // zero counts as the negative side
            if (xv > 0) begin
               y = xv;
            end else begin
               y = -longint'((mag * sl + 64'd32768) >> 16);
            end
         end
         OP_LEAKY_DERIV: begin
            if (xv > 0) begin
               y = 64'sd1 <<< FRAC_BITS;
            end else begin
               y = longint'(((sl << FRAC_BITS) + 64'd32768) >> 16);
            end
         end
         OP_TANH: begin
            t = 2 * sigmoid_q30(2 * mag) - Q30_UNIT;
            y = q30_to_fixed(t);
            if (xv < 0) begin
               y = -y;
            end
         end
         default: begin
            t = 2 * sigmoid_q30(2 * mag) - Q30_UNIT;
            y = q30_to_fixed(Q30_UNIT - ((t * t + Q30_HALF) >> 30));
         end
      endcase
      if (y > SAT_HI) begin
         y = SAT_HI;
      end else if (y < SAT_LO) begin
         y = SAT_LO;
      end
      return DATA_WIDTH'(y);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 50);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
      int v;
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return DATA_WIDTH'($urandom);
      end else if (r < 65) begin
         v = $urandom_range(0, 4095);          // within +-1.0
      end else if (r < 80) begin
         v = $urandom_range(0, 16383);         // tanh saturates past 4.0
      end else if (r < 90) begin
         v = $urandom_range(0, 127) * 256 + $urandom_range(0, 2) - 1;  // near table knots
      end else begin
         case ($urandom_range(0, 5))
            0: return DATA_WIDTH'(SAT_LO);
            1: return DATA_WIDTH'(SAT_HI);
            2: return '0;
            3: return DATA_WIDTH'(-1);
            4: return DATA_WIDTH'(1);
            default: v = 16384;
         endcase
      end
      return DATA_WIDTH'(($urandom_range(0, 1) == 1) ? -v : v);
   endfunction

   task automatic queue_operand(input opcode_type op, input logic signed [DATA_WIDTH-1:0] x);
      operand_item_type itm;
      itm.op = op;
      itm.x  = x;
      pending_operands.push_back(itm);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         queue_operand(opcode_type'($urandom_range(0, 7)), pick_operand());
      end
   endtask

   // pipeline empty and every result back
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_operands.size() != 0 || req_valid || awaited_results.size() != 0);
   endtask

   task automatic slope_phase(input logic [LEAK_W-1:0] slope, input int count);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= slope;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      // leaky edges under the new slope
      queue_operand(OP_LEAKY, DATA_WIDTH'(SAT_LO));
      queue_operand(OP_LEAKY, DATA_WIDTH'(-1));
      queue_operand(OP_LEAKY, '0);
      queue_operand(OP_LEAKY_DERIV, DATA_WIDTH'(SAT_LO));
      queue_operand(OP_LEAKY_DERIV, '0);
      queue_operand(OP_LEAKY_DERIV, DATA_WIDTH'(1));
      queue_random(count);
   endtask

   // ---------------------------------------------------------------- slope shadow

   always @(posedge clock) begin
      if (reset) begin
         slope_shadow <= LEAK_RESET;
      end else if (csr_wr_en) begin
         slope_shadow <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            drv_expect.op = opcode_type'(req_opcode);
            drv_expect.x  = req_x_value;
            drv_expect.y  = activation_value(opcode_type'(req_opcode), req_x_value, slope_shadow);
            awaited_results.push_back(drv_expect);
         end
         if (!req_valid || req_ready) begin
            if (launch_gap > 0) begin
               launch_gap--;
               req_valid <= 1'b0;
            end else if (pending_operands.size() != 0) begin
               drv_item = pending_operands.pop_front();
               req_valid   <= 1'b1;
               req_opcode  <= drv_item.op;
               req_x_value <= drv_item.x;
               if (launch_calm > 0) begin
                  launch_calm--;
               end else begin
                  launch_gap = idle_length();
                  if ($urandom_range(0, 24) == 0) begin
                     launch_calm = $urandom_range(20, 80);
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected item: y=%0d with nothing outstanding", rsp_y_value);
               end
            end else begin
               mon_expect = awaited_results.pop_front();
               if (rsp_y_value !== mon_expect.y) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("y mismatch: op=%0d x=%0d expected %0d got %0d",
                              mon_expect.op, mon_expect.x, mon_expect.y, rsp_y_value);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (accept_calm > 0) begin
               accept_calm--;
            end else begin
               if ($urandom_range(0, 3) == 0) begin
                  stall_left = idle_length();
               end
               if ($urandom_range(0, 39) == 0) begin
                  accept_calm = $urandom_range(20, 80);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      build_sigmoid_knots();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // every opcode at both ends of the range and at zero, default slope
      for (int op = 0; op < 8; op++) begin
         queue_operand(opcode_type'(op), DATA_WIDTH'(SAT_HI));
         queue_operand(opcode_type'(op), DATA_WIDTH'(SAT_LO));
         queue_operand(opcode_type'(op), '0);
      end
      queue_random(100);

      slope_phase('0, 100);
      slope_phase({LEAK_W{1'b1}}, 100);
      slope_phase(LEAK_W'(1), 100);
      slope_phase(LEAK_W'(1) << (LEAK_W - 1), 100);
      slope_phase(LEAK_W'($urandom), 100);
      slope_phase(LEAK_W'($urandom), 100);
      slope_phase(LEAK_RESET, 50);

      wait_drained();
      repeat (PIPE_STAGES * 4) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/nnau_pkg.sv
hdl/nnau_interp.sv
hdl/nnau_finish.sv
hdl/nn_activation_unit_core.sv
hdl/nnau_checker.sv
tb/sv/testbench.sv
